@@ design/tpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// tpfm_pkg
// shared types and constants of the three-phase frequency meter
// ----------------------------------------------------------------------------
`default_nettype none

package tpfm_pkg;

  localparam int NUM_PHASES   = 3;
  localparam int COUNTER_BITS = 16;
  localparam int PHASE_W      = 2;
  localparam int FREQ_W       = 16;
  localparam int NUM_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int DIV_STEPS    = NUM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0]  NUMERATOR_RESET  = NUM_W'(50000000);
  localparam logic [FREQ_W-1:0] LOW_LIMIT_RESET  = FREQ_W'(4500);
  localparam logic [FREQ_W-1:0] HIGH_LIMIT_RESET = FREQ_W'(5500);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = CFG_IDX_W'(2);

  // item function codes
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_CALC = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [PHASE_W-1:0]      phase;
    logic [COUNTER_BITS-1:0] timestamp;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_index;
    logic [FREQ_W-1:0]  frequency;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT
  } state_t;

endpackage

`default_nettype wire

@@ design/tpfm_divider.sv @@
// ----------------------------------------------------------------------------
// tpfm_divider
// restoring divider, one quotient bit per cycle, numerator over period
// ----------------------------------------------------------------------------
`default_nettype none

module tpfm_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [tpfm_pkg::NUM_W-1:0]        dividend,
  input  wire logic [tpfm_pkg::COUNTER_BITS-1:0] divisor,
  output logic                                  busy,
  output logic [tpfm_pkg::NUM_W-1:0]             quotient
);
  import tpfm_pkg::*;

  logic [COUNTER_BITS-1:0] rem;
  logic [COUNTER_BITS-1:0] rem_next;
  logic [COUNTER_BITS-1:0] dvs;
  logic [DIV_CNT_W-1:0]    count;
  logic [COUNTER_BITS:0]   rem_shift;
  logic [COUNTER_BITS:0]   diff;
  logic                    fits;

  always_comb begin
    rem_shift = {rem, quotient[NUM_W-1]};
    diff      = rem_shift - {1'b0, dvs};
    fits      = rem_shift >= {1'b0, dvs};
    rem_next  = fits ? diff[COUNTER_BITS-1:0] : rem_shift[COUNTER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + DIV_CNT_W'(1);
      if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: dividend shifts out of the quotient register as bits come in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[NUM_W-2:0], fits};
      rem      <= rem_next;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider not busy after start");

endmodule

`default_nettype wire

@@ design/three_phase_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// three_phase_frequency_meter
// reciprocal frequency meter for three phases with a reporting window
// ----------------------------------------------------------------------------
// edge request: taken only while idle, no result
// calculate request: three results, one per phase (launch the divider,
//   run its 32 steps, register the result once the output is free)
// throughput set by the shared one-bit-per-cycle divider, used per phase
// synchronous active-high reset: captures zero, config registers to defaults
`default_nettype none

module three_phase_frequency_meter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire tpfm_pkg::item_t                 item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output tpfm_pkg::result_t                    result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpfm_pkg::*;

  // configuration registers
  logic [NUM_W-1:0]  numerator;
  logic [FREQ_W-1:0] low_limit;
  logic [FREQ_W-1:0] high_limit;

  // per-phase capture registers
  logic [COUNTER_BITS-1:0] previous_capture [NUM_PHASES];
  logic [COUNTER_BITS-1:0] latest_capture   [NUM_PHASES];

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [PHASE_W-1:0] phase_cnt;
  logic [PHASE_W-1:0] phase_cnt_next;
  logic               zero_period;

  // divider hookup
  logic                    div_start;
  logic                    div_busy;
  logic [NUM_W-1:0]        div_quotient;
  logic [COUNTER_BITS-1:0] period;

  // result formation
  logic              item_take;
  logic              out_free;
  logic              load_result;
  logic              in_window;
  logic [FREQ_W-1:0] freq_value;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign item_take  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // wrapping period of the phase being worked on
  assign period = latest_capture[phase_cnt] - previous_capture[phase_cnt];

  // saturated quotient, zero period or out of window all report 0
  always_comb begin
    freq_value = div_quotient[FREQ_W-1:0];
    in_window  = !zero_period && (div_quotient[NUM_W-1:FREQ_W] == '0) &&
                 (freq_value >= low_limit) && (freq_value <= high_limit);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      numerator  <= NUMERATOR_RESET;
      low_limit  <= LOW_LIMIT_RESET;
      high_limit <= HIGH_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUMERATOR:  numerator  <= cfg_data[NUM_W-1:0];
        REG_LOW_LIMIT:  low_limit  <= cfg_data[FREQ_W-1:0];
        REG_HIGH_LIMIT: high_limit <= cfg_data[FREQ_W-1:0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // edge capture, unknown phases are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        previous_capture[i] <= '0;
        latest_capture[i]   <= '0;
      end
    end else if (item_take && item.func == FUNC_EDGE &&
                 item.phase < PHASE_W'(NUM_PHASES)) begin
      previous_capture[item.phase] <= latest_capture[item.phase];
      latest_capture[item.phase]   <= item.timestamp;
    end
  end

  // sequencer next state
  always_comb begin
    state_next     = state;
    phase_cnt_next = phase_cnt;
    div_start      = 1'b0;
    load_result    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_take && item.func == FUNC_CALC) begin
          state_next     = ST_LAUNCH;
          phase_cnt_next = '0;
        end
      end
      ST_LAUNCH: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        // hold the quotient until the output register can take it
        if (!div_busy && out_free) begin
          load_result = 1'b1;
          if (phase_cnt == PHASE_W'(NUM_PHASES - 1)) begin
            state_next = ST_IDLE;
          end else begin
            phase_cnt_next = phase_cnt + PHASE_W'(1);
            state_next     = ST_LAUNCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_cnt <= '0;
    end else begin
      state     <= state_next;
      phase_cnt <= phase_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      zero_period <= (period == '0);
    end
  end

  // output register, parts the divider from the downstream side
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.phase_index <= phase_cnt;
      result.frequency   <= in_window ? freq_value : '0;
      result.last        <= (phase_cnt == PHASE_W'(NUM_PHASES - 1));
    end
  end

  tpfm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numerator),
    .divisor  (period),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> state == ST_IDLE)
    else $error("request taken outside idle");

  a_calc_launch: assert property (@(posedge clk) disable iff (rst)
    (item_take && item.func == FUNC_CALC) |=> (state == ST_LAUNCH && phase_cnt == '0))
    else $error("calculate did not start at the first phase");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.phase_index < PHASE_W'(NUM_PHASES))
    else $error("result phase out of range");

  a_last_phase: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> result.phase_index == PHASE_W'(NUM_PHASES - 1))
    else $error("last flag on wrong phase");

endmodule

`default_nettype wire
